// ===== rtl/core/edfmc_pkg.sv =====
`default_nettype none
package edfmc_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int TASK_W      = 8;
  localparam int DL_W        = 16;
  localparam int JCNT_W      = 5;

  localparam logic LVL_LOW = 1'b0;
  localparam logic LVL_TOP = 1'b1;

  typedef enum logic [1:0] {
    REQ_ARRIVE   = 2'd0,
    REQ_COMPLETE = 2'd1,
    REQ_OVERRUN  = 2'd2,
    REQ_NONE     = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BELOW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_POP,
    CMD_PURGE
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PURGE,
    S_FIN
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [TASK_W-1:0] task_id;
    logic [DL_W-1:0]   deadline;
    logic              crit;
  } slot_t;

  typedef struct packed {
    cmd_t  cmd;
    slot_t item;
  } chain_ctl_t;

  localparam slot_t EMPTY_SLOT = '0;

endpackage
`default_nettype wire

// ===== rtl/core/edfmc_cell.sv =====
`default_nettype none
module edfmc_cell (
  input  wire                     clk,
  input  wire                     rst,
  input  edfmc_pkg::chain_ctl_t   ctl,
  input  edfmc_pkg::slot_t        prev_slot,
  input  edfmc_pkg::slot_t        next_slot,
  input  wire                     open_in,
  input  wire                     rm_in,
  output edfmc_pkg::slot_t        q,
  output logic                    stay_out,
  output logic                    rm_out
);
  import edfmc_pkg::*;

  slot_t q_next;

  assign stay_out = q.valid && (q.deadline <= ctl.item.deadline);
  assign rm_out   = rm_in || (ctl.cmd == CMD_PURGE && q.valid && q.crit == LVL_LOW);

  always_comb begin
    q_next = q;
    unique case (ctl.cmd)
      CMD_INSERT: begin
        if (stay_out) begin
          q_next = q;
        end else if (open_in) begin
          q_next = ctl.item;
        end else begin
          q_next = prev_slot;
        end
      end
      CMD_POP, CMD_PURGE: begin
        if (rm_out) begin
          q_next = next_slot;
        end
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else begin
      q <= q_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/edfmc_chain.sv =====
`default_nettype none
module edfmc_chain (
  input  wire                     clk,
  input  wire                     rst,
  input  edfmc_pkg::chain_ctl_t   ctl,
  output edfmc_pkg::slot_t        head,
  output logic                    low_any
);
  import edfmc_pkg::*;

  slot_t q     [QUEUE_DEPTH];
  slot_t prv   [QUEUE_DEPTH];
  slot_t nxt   [QUEUE_DEPTH];
  logic  open  [QUEUE_DEPTH];
  logic  rmi   [QUEUE_DEPTH];
  logic  stay  [QUEUE_DEPTH];
  logic  rmo   [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prv[i]  = EMPTY_SLOT;
      assign open[i] = 1'b1;
      assign rmi[i]  = (ctl.cmd == CMD_POP);
    end else begin : g_rest
      assign prv[i]  = q[i-1];
      assign open[i] = stay[i-1];
      assign rmi[i]  = rmo[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nxt[i] = EMPTY_SLOT;
    end else begin : g_mid
      assign nxt[i] = q[i+1];
    end

    edfmc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .prev_slot (prv[i]),
      .next_slot (nxt[i]),
      .open_in   (open[i]),
      .rm_in     (rmi[i]),
      .q         (q[i]),
      .stay_out  (stay[i]),
      .rm_out    (rmo[i])
    );
  end

  assign head    = q[0];
  assign low_any = rmo[QUEUE_DEPTH-1];

endmodule
`default_nettype wire

// ===== rtl/core/edf_mixed_criticality_ready_queue.sv =====
// Flow: an accepted arrival, completion or idle code is applied to the cell chain, and S_FIN
//   loads its result; an overrun first purges low-criticality jobs, one per cycle.
// A new transaction is taken only in S_IDLE, after S_FIN loads the last result (which can
//   wait on out_ready); the cell chain registers the insert or pop and S_FIN reads the head.
// Reset: synchronous, active high; empties the queue, level low, no running job.
`default_nettype none
module edf_mixed_criticality_ready_queue (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [1:0]                   req_type,
  input  wire  [edfmc_pkg::TASK_W-1:0] task_id,
  input  wire                          task_crit,
  input  wire  [edfmc_pkg::DL_W-1:0]   abs_deadline,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [1:0]                   status,
  output logic                         head_valid,
  output logic [edfmc_pkg::TASK_W-1:0] head_task,
  output logic [edfmc_pkg::DL_W-1:0]   head_deadline,
  output logic                         crit_now,
  output logic                         switched,
  output logic [edfmc_pkg::JCNT_W-1:0] job_count
);
  import edfmc_pkg::*;

  state_t            state, state_next;
  status_t           status_q, status_next;
  logic [CNT_W-1:0]  count, count_next;
  logic              level, level_next;
  logic              run_valid;
  logic [TASK_W-1:0] run_task;
  logic [DL_W-1:0]   run_deadline;
  logic              stop_run;
  logic              fin_load;
  logic              accept;
  logic              dispatch;
  logic              low_any;
  req_t              req;
  cmd_t              chain_cmd;
  chain_ctl_t        ctl;
  slot_t             head;

  assign req      = req_t'(req_type);
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign ctl = {chain_cmd, 1'b1, task_id, abs_deadline, task_crit};

  edfmc_chain u_chain (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .head    (head),
    .low_any (low_any)
  );

  assign dispatch = head.valid &&
                    (!run_valid || run_task != head.task_id || run_deadline != head.deadline);

  always_comb begin
    state_next  = state;
    status_next = status_q;
    count_next  = count;
    level_next  = level;
    chain_cmd   = CMD_HOLD;
    stop_run    = 1'b0;
    fin_load    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next  = S_FIN;
          status_next = ST_OK;
          unique case (req)
            REQ_ARRIVE: begin
              if (task_crit < level) begin
                status_next = ST_BELOW;
              end else if (count == CNT_W'(QUEUE_DEPTH)) begin
                status_next = ST_FULL;
              end else begin
                chain_cmd  = CMD_INSERT;
                count_next = count + 1'b1;
              end
            end
            REQ_COMPLETE: begin
              if (count == '0) begin
                status_next = ST_EMPTY;
              end else begin
                chain_cmd  = CMD_POP;
                count_next = count - 1'b1;
                stop_run   = 1'b1;
              end
            end
            REQ_OVERRUN: begin
              level_next = LVL_TOP;
              state_next = S_PURGE;
            end
            default: begin
            end
          endcase
        end
      end
      S_PURGE: begin
        chain_cmd = CMD_PURGE;
        if (low_any) begin
          count_next = count - 1'b1;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          fin_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      status_q <= ST_OK;
      count    <= '0;
      level    <= LVL_LOW;
    end else begin
      state    <= state_next;
      status_q <= status_next;
      count    <= count_next;
      level    <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid    <= 1'b0;
      run_task     <= '0;
      run_deadline <= '0;
    end else if (stop_run) begin
      run_valid <= 1'b0;
    end else if (fin_load) begin
      if (!head.valid) begin
        run_valid <= 1'b0;
      end else if (dispatch) begin
        run_valid    <= 1'b1;
        run_task     <= head.task_id;
        run_deadline <= head.deadline;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      status        <= status_q;
      head_valid    <= head.valid;
      head_task     <= head.valid ? head.task_id : '0;
      head_deadline <= head.valid ? head.deadline : '0;
      crit_now      <= level;
      switched      <= dispatch;
      job_count     <= JCNT_W'(count);
    end
  end

`ifndef SYNTHESIS
  a_count_head: assert property (@(posedge clk) disable iff (rst)
    (count == '0) == !head.valid)
    else $error("job count disagrees with head cell");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("job count beyond queue depth");

  a_purge_level: assert property (@(posedge clk) disable iff (rst)
    state == S_PURGE |-> level == LVL_TOP)
    else $error("purge running below top level");

  a_fin_out: assert property (@(posedge clk) disable iff (rst)
    fin_load |=> out_valid)
    else $error("finished transaction not presented");
`endif

endmodule
`default_nettype wire
